### rtl/ecc_pkg.sv
// Shared types and constants for the evaporative cooler controller.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

    // Temperatures are tenths of a degree F
    localparam int TEMP_W = 12;
    localparam int SP_W   = 10;
    localparam int CFG_W  = 22;
    localparam int IDX_W  = 3;
    localparam int TIME_W = 32;
    localparam int IVL_W  = 16;
    localparam int WET_W  = 22;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [TEMP_W:0]   wtemp_t;
    typedef logic [1:0]               mode_t;

    localparam mode_t MODE_AUTO = 2'd0;
    localparam mode_t MODE_OFF  = 2'd1;
    localparam mode_t MODE_ON   = 2'd2;

    typedef enum logic [IDX_W-1:0] {
        CFG_VACATION   = 3'd0,
        CFG_DAY_SP     = 3'd1,
        CFG_NIGHT_MAX  = 3'd2,
        CFG_NIGHT_MIN  = 3'd3,
        CFG_FAN_MODE   = 3'd4,
        CFG_PUMP_MODE  = 3'd5,
        CFG_INTERVAL   = 3'd6,
        CFG_WET_DELAY  = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam logic [SP_W-1:0]  DAY_SP_RST    = 10'd750;
    localparam logic [SP_W-1:0]  NIGHT_MAX_RST = 10'd780;
    localparam logic [SP_W-1:0]  NIGHT_MIN_RST = 10'd680;
    localparam logic [IVL_W-1:0] INTERVAL_RST  = 16'd1000;
    localparam logic [WET_W-1:0] WET_DELAY_RST = 22'd300000;

    // Thermostat thresholds
    localparam wtemp_t REMOTE_VALID_MIN = 13'sd320;
    localparam wtemp_t VAC_REMOTE_MIN   = 13'sd650;
    localparam wtemp_t NIGHT_OFFSET     = 13'sd10;
    localparam wtemp_t SC_DROP          = 13'sd5;
    localparam wtemp_t SC_RAISE         = 13'sd1;
    localparam wtemp_t WET_DONE_TEMP    = 13'sd700;
    localparam wtemp_t DAY_PUMP_LO      = 13'sd660;
    localparam wtemp_t DAY_PUMP_HI      = 13'sd670;
    localparam wtemp_t NIGHT_PUMP_LO    = 13'sd705;
    localparam wtemp_t NIGHT_PUMP_HI    = 13'sd710;

endpackage

`default_nettype wire

### rtl/evaporative_cooler_controller_unit.sv
// Top level of the evaporative cooler controller: input register, control step, held state.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | in        | in_valid / in_stall      | now_ms, indoor/outdoor/remote_temp,
//          |           |                          | sun_up, wall_cool_call
//  out     | out       | out_valid / out_stall    | evaluated, fan_on, pump_on,
//          |           |                          | cooling_call, setpoint, waiting_for_wet
//  cfg     | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; an item passes the input register, then the step
// into the state/result registers. Result fields are read straight from the held controller state.
// The interval check, set point clamp and wet-wait compare form the one combinational pass.
// Reset clears the valid flags and controller state and loads the register defaults; cfg_ready is always high.
// A stalled result holds the state frozen; the input register fills and then stalls upstream.
`timescale 1ns / 1ps
`default_nettype none

module evaporative_cooler_controller_unit
    import ecc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [TIME_W-1:0]       now_ms,
    input  wire logic signed [TEMP_W-1:0] indoor_temp,
    input  wire logic signed [TEMP_W-1:0] outdoor_temp,
    input  wire logic signed [TEMP_W-1:0] remote_temp,
    input  wire logic                    sun_up,
    input  wire logic                    wall_cool_call,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         evaluated,
    output logic                         fan_on,
    output logic                         pump_on,
    output logic                         cooling_call,
    output logic signed [TEMP_W-1:0]     setpoint,
    output logic                         waiting_for_wet,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    // Configuration registers
    logic             vacation_reg;
    logic [SP_W-1:0]  day_sp_reg;
    logic [SP_W-1:0]  night_max_reg;
    logic [SP_W-1:0]  night_min_reg;
    mode_t            fan_mode_reg;
    mode_t            pump_mode_reg;
    logic [IVL_W-1:0] interval_reg;
    logic [WET_W-1:0] wet_delay_reg;

    // Input register
    logic              in_vld_reg;
    logic [TIME_W-1:0] now_reg;
    temp_t             indoor_reg;
    temp_t             outdoor_reg;
    temp_t             remote_reg;
    logic              sun_reg;
    logic              wall_reg;

    // Controller state, doubling as the result register
    logic              out_vld_reg;
    logic              eval_reg;
    logic              prev_call_reg;
    logic              short_cycle_reg;
    logic              wet_wait_reg;
    logic [TIME_W-1:0] wet_start_reg;
    logic [TIME_W-1:0] last_eval_reg;
    logic              pump_reg;
    logic              fan_reg;
    temp_t             sp_reg;

    logic out_free;
    logic step_go;
    logic in_load;

    logic [TIME_W-1:0] since_eval;
    logic [TIME_W-1:0] since_wet;
    logic              due;

    wtemp_t indoor_w;
    wtemp_t outdoor_w;
    wtemp_t remote_w;
    wtemp_t night_raw;
    wtemp_t night_hi;
    wtemp_t sp_base;
    wtemp_t sp_adj;

    logic   call;
    logic   sp_update;
    logic   rising;
    logic   wet_active;
    logic   wet_done;
    logic   fan_auto;
    logic   pump_auto;
    logic   fan_final;
    logic   pump_final;
    logic   wet_wait_next;
    wtemp_t pump_lo;
    wtemp_t pump_hi;

    // Handshake: result slot frees when empty or taken this cycle
    assign out_free  = !out_vld_reg || !out_stall;
    assign step_go   = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign in_load   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vacation_reg  <= 1'b0;
            day_sp_reg    <= DAY_SP_RST;
            night_max_reg <= NIGHT_MAX_RST;
            night_min_reg <= NIGHT_MIN_RST;
            fan_mode_reg  <= MODE_AUTO;
            pump_mode_reg <= MODE_AUTO;
            interval_reg  <= INTERVAL_RST;
            wet_delay_reg <= WET_DELAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VACATION:  vacation_reg  <= cfg_data[0];
                CFG_DAY_SP:    day_sp_reg    <= cfg_data[SP_W-1:0];
                CFG_NIGHT_MAX: night_max_reg <= cfg_data[SP_W-1:0];
                CFG_NIGHT_MIN: night_min_reg <= cfg_data[SP_W-1:0];
                CFG_FAN_MODE:  fan_mode_reg  <= cfg_data[1:0];
                CFG_PUMP_MODE: pump_mode_reg <= cfg_data[1:0];
                CFG_INTERVAL:  interval_reg  <= cfg_data[IVL_W-1:0];
                CFG_WET_DELAY: wet_delay_reg <= cfg_data[WET_W-1:0];
                default:       vacation_reg  <= vacation_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (step_go)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            now_reg     <= now_ms;
            indoor_reg  <= indoor_temp;
            outdoor_reg <= outdoor_temp;
            remote_reg  <= remote_temp;
            sun_reg     <= sun_up;
            wall_reg    <= wall_cool_call;
        end
    end

    // Interval and wet-wait timing, modulo 2^32
    assign since_eval = now_reg - last_eval_reg;
    assign since_wet  = now_reg - wet_start_reg;
    assign due        = since_eval >= {{(TIME_W-IVL_W){1'b0}}, interval_reg};

    assign indoor_w  = {indoor_reg[TEMP_W-1], indoor_reg};
    assign outdoor_w = {outdoor_reg[TEMP_W-1], outdoor_reg};
    assign remote_w  = {remote_reg[TEMP_W-1], remote_reg};

    // Set point: day value, or outdoor minus one degree clamped max then min, then short-cycle adjusted
    always_comb
    begin
        night_raw = outdoor_w - NIGHT_OFFSET;
        night_hi  = (night_raw > $signed({3'b000, night_max_reg}))
                    ? $signed({3'b000, night_max_reg}) : night_raw;
        if (sun_reg)
        begin
            sp_base = $signed({3'b000, day_sp_reg});
        end
        else if (night_hi < $signed({3'b000, night_min_reg}))
        begin
            sp_base = $signed({3'b000, night_min_reg});
        end
        else
        begin
            sp_base = night_hi;
        end
        sp_adj = short_cycle_reg ? (sp_base - SC_DROP) : (sp_base + SC_RAISE);
    end

    // Cooling call
    always_comb
    begin
        sp_update = 1'b0;
        if (vacation_reg)
        begin
            call = !sun_reg && !(remote_w < VAC_REMOTE_MIN) && (outdoor_w < remote_w);
        end
        else if (remote_w < REMOTE_VALID_MIN)
        begin
            call = wall_reg;
        end
        else
        begin
            sp_update = 1'b1;
            call      = remote_w > sp_adj;
        end
    end

    // Pre-wet wait and pump hysteresis
    always_comb
    begin
        rising        = call && !prev_call_reg;
        wet_active    = rising || wet_wait_reg;
        // a fresh wait has zero elapsed time, so only the temperature can end it
        wet_done      = (indoor_w < WET_DONE_TEMP) || (!rising && (since_wet > {
                        {(TIME_W-WET_W){1'b0}}, wet_delay_reg}));
        pump_lo       = sun_reg ? DAY_PUMP_LO : NIGHT_PUMP_LO;
        pump_hi       = sun_reg ? DAY_PUMP_HI : NIGHT_PUMP_HI;
        fan_auto      = 1'b0;
        pump_auto     = 1'b0;
        wet_wait_next = wet_wait_reg;
        if (call)
        begin
            if (wet_active)
            begin
                pump_auto     = 1'b1;
                fan_auto      = wet_done;
                wet_wait_next = !wet_done;
            end
            else
            begin
                fan_auto = 1'b1;
                if (indoor_w > pump_hi)
                begin
                    pump_auto = 1'b1;
                end
                else if (indoor_w < pump_lo)
                begin
                    pump_auto = 1'b0;
                end
                else
                begin
                    pump_auto = pump_reg;
                end
            end
        end
        fan_final  = (fan_mode_reg == MODE_ON) ||
                     (fan_auto && (fan_mode_reg != MODE_OFF));
        pump_final = (pump_mode_reg == MODE_ON) ||
                     (pump_auto && !vacation_reg && (pump_mode_reg != MODE_OFF));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg     <= 1'b0;
            eval_reg        <= 1'b0;
            prev_call_reg   <= 1'b0;
            short_cycle_reg <= 1'b0;
            wet_wait_reg    <= 1'b0;
            wet_start_reg   <= '0;
            last_eval_reg   <= '0;
            pump_reg        <= 1'b0;
            fan_reg         <= 1'b0;
            sp_reg          <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (step_go)
            begin
                eval_reg <= due;
                if (due)
                begin
                    last_eval_reg <= now_reg;
                    prev_call_reg <= call;
                    wet_wait_reg  <= wet_wait_next;
                    fan_reg       <= fan_final;
                    pump_reg      <= pump_final;
                    if (rising)
                    begin
                        wet_start_reg <= now_reg;
                    end
                    if (sp_update)
                    begin
                        sp_reg          <= sp_adj[TEMP_W-1:0];
                        short_cycle_reg <= call;
                    end
                end
            end
        end
    end

    assign out_valid       = out_vld_reg;
    assign evaluated       = eval_reg;
    assign fan_on          = fan_reg;
    assign pump_on         = pump_reg;
    assign cooling_call    = prev_call_reg;
    assign setpoint        = sp_reg;
    assign waiting_for_wet = wet_wait_reg;

    // A skipped item repeats the held outputs
    a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && !due) |=> (!evaluated && $stable(fan_on) && $stable(pump_on) &&
                               $stable(cooling_call) && $stable(setpoint) &&
                               $stable(waiting_for_wet)))
        else $error("skipped item changed held outputs");

    // Upstream stalls only when the input register holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("input stalled with empty input register");

    // Forced pump mode wins over everything
    a_pump_forced: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && due && pump_mode_reg == MODE_ON) |=> pump_on)
        else $error("pump not forced on");

    // Vacation keeps the pump off unless forced on
    a_vacation_pump: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && due && vacation_reg && pump_mode_reg != MODE_ON) |=> !pump_on)
        else $error("pump on during vacation");

    // A stalled result does not move the state
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> ($stable(last_eval_reg) && out_vld_reg))
        else $error("state moved while result stalled");

endmodule

`default_nettype wire
